/* rtl/vum_pkg.sv */
// ----------------------------------------------------------------------------
// vum_pkg : shared types and constants for the VU meter block
// Field widths, register codes, reset values and the memory word layouts.
// ----------------------------------------------------------------------------
package vum_pkg;

	localparam int LEVEL_W = 13;
	localparam int AGE_W   = 16;
	localparam int CHAN_W  = 3;
	localparam int VISIT_MAX = 8;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 13'd4096;
	localparam logic [AGE_W-1:0]   AGE_MAX    = 16'hFFFF;

	// register reset values
	localparam logic [LEVEL_W-1:0] DECAY_STEP_RST     = 13'd341;
	localparam logic [LEVEL_W-1:0] ZERO_FLOOR_RST     = 13'd41;
	localparam logic [AGE_W-1:0]   DECAY_INTERVAL_RST = 16'd100;
	localparam logic [AGE_W-1:0]   HOLD_TIME_RST      = 16'd2000;

	// register index codes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_DECAY_STEP     = 2'd0,
		REG_ZERO_FLOOR     = 2'd1,
		REG_DECAY_INTERVAL = 2'd2,
		REG_HOLD_TIME      = 2'd3
	} reg_idx_t;

	// settings handed from the register file to the datapath
	typedef struct packed {
		logic [LEVEL_W-1:0] decay_step;
		logic [LEVEL_W-1:0] zero_floor;
		logic [AGE_W-1:0]   decay_interval;
		logic [AGE_W-1:0]   hold_time;
	} cfg_t;

	// level memory word
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [AGE_W-1:0]   decay_age;
	} lvl_word_t;

	// peak memory word
	typedef struct packed {
		logic [LEVEL_W-1:0] peak;
		logic [AGE_W-1:0]   hold_age;
	} pk_word_t;

endpackage

/* rtl/vum_ram.sv */
// ----------------------------------------------------------------------------
// vum_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module vum_ram #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/vum_regs.sv */
// ----------------------------------------------------------------------------
// vum_regs : APB register file
// Holds decay step, zero floor, decay interval and hold time.
// ----------------------------------------------------------------------------
module vum_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output vum_pkg::cfg_t      cfg
);

	vum_pkg::cfg_t      cfg_q;
	vum_pkg::reg_idx_t  idx;
	logic               wr_en;

	// word index; the low address bits select nothing
	assign idx    = vum_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay_step     <= vum_pkg::DECAY_STEP_RST;
			cfg_q.zero_floor     <= vum_pkg::ZERO_FLOOR_RST;
			cfg_q.decay_interval <= vum_pkg::DECAY_INTERVAL_RST;
			cfg_q.hold_time      <= vum_pkg::HOLD_TIME_RST;
		end else if (wr_en) begin
			case (idx)
				vum_pkg::REG_DECAY_STEP:     cfg_q.decay_step     <= pwdata[12:0];
				vum_pkg::REG_ZERO_FLOOR:     cfg_q.zero_floor     <= pwdata[12:0];
				vum_pkg::REG_DECAY_INTERVAL: cfg_q.decay_interval <= pwdata[15:0];
				vum_pkg::REG_HOLD_TIME:      cfg_q.hold_time      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			vum_pkg::REG_DECAY_STEP:     prdata = 32'(cfg_q.decay_step);
			vum_pkg::REG_ZERO_FLOOR:     prdata = 32'(cfg_q.zero_floor);
			vum_pkg::REG_DECAY_INTERVAL: prdata = 32'(cfg_q.decay_interval);
			vum_pkg::REG_HOLD_TIME:      prdata = 32'(cfg_q.hold_time);
			default:                     prdata = '0;
		endcase
	end

endmodule

/* rtl/vu_meter_decay_peak_hold.sv */
// ----------------------------------------------------------------------------
// vu_meter_decay_peak_hold : per-channel VU level decay with peak hold
// Level and peak state live in two small RAMs; a tick sweeps the channels.
// ----------------------------------------------------------------------------
//
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------
// in       in_valid / in_ready  kind, channel, new_level
// out      out_valid/out_ready  out_channel, out_level, out_peak,
//                               channel_changed, redraw, last
// cfg      APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// A level transaction writes the level RAM directly.
// A tick is accepted, then sweeps min(CHANNELS,8) channels, one channel per cycle
// through the read port of each RAM while out is not stalled; each read is
// registered in the RAM before the datapath updates it and writes it back.
// Out stalls hold the sweep; the input is accepted again once the last read
// has been written back, even while the final result waits in the output.
// Reset clears the entry valid bits, so all state reads as zero at once.
//
module vu_meter_decay_peak_hold #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [2:0]  channel,
	input  logic [12:0] new_level,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_channel,
	output logic [12:0] out_level,
	output logic [12:0] out_peak,
	output logic        channel_changed,
	output logic        redraw,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int VISIT = (CHANNELS < vum_pkg::VISIT_MAX) ? CHANNELS : vum_pkg::VISIT_MAX;
	localparam int IW    = (VISIT > 1) ? $clog2(VISIT) : 1;
	localparam int LW    = vum_pkg::LEVEL_W;
	localparam int GW    = vum_pkg::AGE_W;

	vum_pkg::cfg_t      cfg;
	vum_pkg::lvl_word_t lvl_rd, lvl_wr, lvl_rmw;
	vum_pkg::pk_word_t  pk_rd, pk_rmw;

	// control
	logic                busy_q;
	logic [IW:0]         rd_cnt_q;
	logic                s1_valid_q;
	logic [IW-1:0]       s1_idx_q;
	logic                s1_va_q, s1_vb_q;
	logic                any_q;
	logic [CHANNELS-1:0] va_q, vb_q;
	logic                out_valid_q;

	logic          in_acc, lvl_we, tick_start;
	logic          adv, issue, s1_last;
	logic [AW-1:0] rd_addr, wb_addr, lvl_addr, ld_addr;
	logic          chan_ok;
	logic [LW-1:0] ld_level;

	// read-modify-write datapath
	logic [LW-1:0] lvl0, pk0, lvl_dec, lvl_sub, lvl2, pk2, pk3;
	logic [GW-1:0] dage0, hage0, dage1, hage1, dage2, hage2;
	logic          decay, drop, raise, changed;

	vum_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input side
	assign in_ready   = !busy_q;
	assign in_acc     = in_valid && in_ready;
	assign chan_ok    = {4'b0, channel} < 7'(CHANNELS);
	assign lvl_we     = in_acc && kind && chan_ok;
	assign tick_start = in_acc && !kind;
	assign ld_addr    = AW'(channel);
	assign ld_level   = (new_level > vum_pkg::FULL_SCALE) ? vum_pkg::FULL_SCALE : new_level;

	// sweep control: advance when the output register can take a result
	assign adv     = s1_valid_q && (!out_valid_q || out_ready);
	assign issue   = busy_q && (rd_cnt_q < (IW+1)'(VISIT)) && (!s1_valid_q || adv);
	assign rd_addr = AW'(rd_cnt_q[IW-1:0]);
	assign wb_addr = AW'(s1_idx_q);
	assign s1_last = (s1_idx_q == IW'(VISIT - 1));

	// level RAM write port is shared by level loads and tick write-back
	assign lvl_addr = adv ? wb_addr : ld_addr;
	always_comb begin
		if (adv) begin
			lvl_wr = lvl_rmw;
		end else begin
			lvl_wr.level     = ld_level;
			lvl_wr.decay_age = '0;
		end
	end

	vum_ram #(
		.WIDTH ($bits(vum_pkg::lvl_word_t)),
		.DEPTH (CHANNELS)
	) u_lvl_ram (
		.clk   (clk),
		.we    (lvl_we || adv),
		.waddr (lvl_addr),
		.wdata (lvl_wr),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (lvl_rd)
	);

	vum_ram #(
		.WIDTH ($bits(vum_pkg::pk_word_t)),
		.DEPTH (CHANNELS)
	) u_pk_ram (
		.clk   (clk),
		.we    (adv),
		.waddr (wb_addr),
		.wdata (pk_rmw),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (pk_rd)
	);

	// per-channel tick update
	always_comb begin
		lvl0  = s1_va_q ? lvl_rd.level     : '0;
		dage0 = s1_va_q ? lvl_rd.decay_age : '0;
		pk0   = s1_vb_q ? pk_rd.peak       : '0;
		hage0 = s1_vb_q ? pk_rd.hold_age   : '0;

		// saturating ages
		dage1 = (dage0 == vum_pkg::AGE_MAX) ? dage0 : dage0 + 1'b1;
		hage1 = (hage0 == vum_pkg::AGE_MAX) ? hage0 : hage0 + 1'b1;

		// level decay with snap to zero under the floor
		decay   = (lvl0 != '0) && (dage1 > cfg.decay_interval);
		lvl_sub = (cfg.decay_step > lvl0) ? '0 : lvl0 - cfg.decay_step;
		lvl_dec = (lvl_sub < cfg.zero_floor) ? '0 : lvl_sub;
		lvl2    = decay ? lvl_dec : lvl0;
		dage2   = decay ? '0 : dage1;

		// peak drop after hold, then peak raise
		drop  = (pk0 != '0) && (hage1 > cfg.hold_time) && (pk0 > lvl2);
		pk2   = drop ? lvl2 : pk0;
		raise = pk2 < lvl2;
		pk3   = raise ? lvl2 : pk2;
		hage2 = raise ? '0 : hage1;

		changed = decay || drop || raise;

		lvl_rmw.level     = lvl2;
		lvl_rmw.decay_age = dage2;
		pk_rmw.peak       = pk3;
		pk_rmw.hold_age   = hage2;
	end

	// sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rd_cnt_q   <= '0;
			s1_valid_q <= 1'b0;
			s1_idx_q   <= '0;
			s1_va_q    <= 1'b0;
			s1_vb_q    <= 1'b0;
			any_q      <= 1'b0;
		end else begin
			if (tick_start) begin
				busy_q   <= 1'b1;
				rd_cnt_q <= '0;
				any_q    <= 1'b0;
			end
			if (issue) begin
				rd_cnt_q   <= rd_cnt_q + 1'b1;
				s1_valid_q <= 1'b1;
				s1_idx_q   <= rd_cnt_q[IW-1:0];
				s1_va_q    <= va_q[rd_addr];
				s1_vb_q    <= vb_q[rd_addr];
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				any_q <= any_q || changed;
				if (s1_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// entry valid bits: an entry not yet written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= '0;
			vb_q <= '0;
		end else begin
			if (lvl_we || adv) begin
				va_q[lvl_addr] <= 1'b1;
			end
			if (adv) begin
				vb_q[wb_addr] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_channel     <= 3'(s1_idx_q);
			out_level       <= lvl2;
			out_peak        <= pk3;
			channel_changed <= changed;
			redraw          <= s1_last && (any_q || changed);
			last            <= s1_last;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_s1_in_sweep : assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> busy_q)
		else $error("stage 1 holds a channel outside a tick sweep");

	a_rd_cnt_range : assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= (IW+1)'(VISIT))
		else $error("read counter ran past the channel count");

	a_last_chan : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last |-> out_channel == 3'(VISIT - 1))
		else $error("last flag on a channel other than the final one");

	a_redraw_last : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && redraw |-> last)
		else $error("redraw flagged on a result that is not the last");

	a_sweep_done : assert property (@(posedge clk) disable iff (!arst_n)
		adv && s1_last |=> !busy_q && !s1_valid_q)
		else $error("sweep still active after the last channel");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench : self-checking bench for vu_meter_decay_peak_hold
// Drives level and tick transactions with random bursts and output stalls,
// rewrites the four settings between phases over the APB port, and checks
// every per-channel result against a shadow copy of the meter state.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_CH            = 8;
	localparam int IDLE_GUARD      = 16;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 78;

	// transaction kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_LEVEL = 1'b1;

	// receiver stall modes
	localparam int RX_FLOW   = 0;
	localparam int RX_PATCHY = 1;
	localparam int RX_SPARSE = 2;

	typedef struct packed {
		logic [vum_pkg::CHAN_W-1:0]  chan;
		logic [vum_pkg::LEVEL_W-1:0] level;
		logic [vum_pkg::LEVEL_W-1:0] peak;
		logic                        changed;
		logic                        redraw;
		logic                        last;
	} reading_t;

	// Shadow copy of the meter: mirrors settings and per-channel state,
	// queues the readings each tick should produce and checks them.
	class vu_meter_shadow;
		logic [vum_pkg::LEVEL_W-1:0] step, floor_lvl;
		logic [vum_pkg::AGE_W-1:0]   interval, hold;
		logic [vum_pkg::LEVEL_W-1:0] level_mem [N_CH];
		logic [vum_pkg::LEVEL_W-1:0] peak_mem  [N_CH];
		logic [vum_pkg::AGE_W-1:0]   decay_age [N_CH];
		logic [vum_pkg::AGE_W-1:0]   hold_age  [N_CH];
		reading_t                    due_readings [$];
		int unsigned                 faults;

		function new();
			step      = vum_pkg::DECAY_STEP_RST;
			floor_lvl = vum_pkg::ZERO_FLOOR_RST;
			interval  = vum_pkg::DECAY_INTERVAL_RST;
			hold      = vum_pkg::HOLD_TIME_RST;
			for (int i = 0; i < N_CH; i++) begin
				level_mem[i] = '0;
				peak_mem[i]  = '0;
				decay_age[i] = '0;
				hold_age[i]  = '0;
			end
			faults = 0;
		endfunction

		function void write_reg(vum_pkg::reg_idx_t r, logic [31:0] v);
			case (r)
				vum_pkg::REG_DECAY_STEP:     step      = v[vum_pkg::LEVEL_W-1:0];
				vum_pkg::REG_ZERO_FLOOR:     floor_lvl = v[vum_pkg::LEVEL_W-1:0];
				vum_pkg::REG_DECAY_INTERVAL: interval  = v[vum_pkg::AGE_W-1:0];
				vum_pkg::REG_HOLD_TIME:      hold      = v[vum_pkg::AGE_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(vum_pkg::reg_idx_t r);
			case (r)
				vum_pkg::REG_DECAY_STEP:     return 32'(step);
				vum_pkg::REG_ZERO_FLOOR:     return 32'(floor_lvl);
				vum_pkg::REG_DECAY_INTERVAL: return 32'(interval);
				default:                     return 32'(hold);
			endcase
		endfunction

		// level transaction loads one channel; a tick sweeps them all
		function void absorb_item(logic k, logic [vum_pkg::CHAN_W-1:0] ch,
				logic [vum_pkg::LEVEL_W-1:0] nl);
			reading_t                    sweep [vum_pkg::VISIT_MAX];
			logic [vum_pkg::LEVEL_W-1:0] lvl;
			bit                          any, chg;
			int                          visits;
			if (k == KIND_LEVEL) begin
				if (ch < N_CH) begin
					level_mem[ch] = (nl > vum_pkg::FULL_SCALE) ? vum_pkg::FULL_SCALE : nl;
					decay_age[ch] = '0;
				end
			end else begin
				visits = (N_CH < vum_pkg::VISIT_MAX) ? N_CH : vum_pkg::VISIT_MAX;
				any = 1'b0;
				for (int i = 0; i < visits; i++) begin
					chg = 1'b0;
					// ages saturate rather than wrap
					if (decay_age[i] != vum_pkg::AGE_MAX) decay_age[i] = decay_age[i] + 1'b1;
					if (hold_age[i] != vum_pkg::AGE_MAX) hold_age[i] = hold_age[i] + 1'b1;
					lvl = level_mem[i];
					if (lvl != 0 && decay_age[i] > interval) begin
						lvl = (step > lvl) ? '0 : lvl - step;
						if (lvl < floor_lvl) lvl = '0;
						level_mem[i] = lvl;
						decay_age[i] = '0;
						chg = 1'b1;
					end
					// held too long: peak falls to the level
					if (peak_mem[i] != 0 && hold_age[i] > hold && peak_mem[i] > lvl) begin
						peak_mem[i] = lvl;
						chg = 1'b1;
					end
					if (peak_mem[i] < lvl) begin
						peak_mem[i] = lvl;
						hold_age[i] = '0;
						chg = 1'b1;
					end
					any = any | chg;
					sweep[i].chan    = vum_pkg::CHAN_W'(i);
					sweep[i].level   = level_mem[i];
					sweep[i].peak    = peak_mem[i];
					sweep[i].changed = chg;
					sweep[i].redraw  = 1'b0;
					sweep[i].last    = (i == visits - 1);
				end
				sweep[visits-1].redraw = any;
				for (int i = 0; i < visits; i++) due_readings.push_back(sweep[i]);
			end
		endfunction

		function void check_reading(reading_t seen);
			reading_t want;
			if (due_readings.size() == 0) begin
				$display("%0t: result with none pending: ch %0d level %0d peak %0d",
					$time, seen.chan, seen.level, seen.peak);
				faults++;
			end else begin
				want = due_readings.pop_front();
				if (seen !== want) begin
					$display("%0t: expected ch %0d level %0d peak %0d chg %0b redraw %0b last %0b",
						$time, want.chan, want.level, want.peak, want.changed,
						want.redraw, want.last);
					$display("%0t: actual   ch %0d level %0d peak %0d chg %0b redraw %0b last %0b",
						$time, seen.chan, seen.level, seen.peak, seen.changed,
						seen.redraw, seen.last);
					faults++;
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               kind      = KIND_TICK;
	logic [2:0]         channel   = '0;
	logic [12:0]        new_level = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         out_channel;
	logic [12:0]        out_level;
	logic [12:0]        out_peak;
	logic               channel_changed;
	logic               redraw;
	logic               last;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [3:0]         paddr     = '0;
	logic [31:0]        pwdata    = '0;
	logic [31:0]        prdata;
	logic               pready;

	vu_meter_shadow shadow = new();

	// sender and receiver pacing controls
	bit          tx_no_gaps = 1'b0;
	bit          full_speed = 1'b0;
	bit          squeeze    = 1'b0;
	int unsigned burst_left = 0;

	vu_meter_decay_peak_hold #(.CHANNELS(N_CH)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			shadow.check_reading(reading_t'({out_channel, out_level, out_peak,
				channel_changed, redraw, last}));
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin : ready_pattern
		int unsigned run_left;
		int unsigned mode;
		run_left = 0;
		mode = RX_FLOW;
		forever begin
			@(negedge clk);
			if (squeeze) begin
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				squeeze = 1'b0;
			end else if (full_speed) begin
				out_ready = 1'b1;
			end else begin
				if (run_left == 0) begin
					mode = $urandom_range(RX_FLOW, RX_SPARSE);
					run_left = $urandom_range(4, 60);
				end
				run_left--;
				case (mode)
					RX_FLOW:   out_ready = 1'b1;
					RX_PATCHY: out_ready = 1'($urandom_range(0, 1));
					default:   out_ready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// one input transaction, then possibly a gap before the next burst
	task automatic send_item(input logic k, input logic [2:0] ch, input logic [12:0] nl);
		int unsigned gap;
		@(negedge clk);
		in_valid  = 1'b1;
		kind      = k;
		channel   = ch;
		new_level = nl;
		do @(posedge clk); while (!in_ready);
		shadow.absorb_item(k, ch, nl);
		if (!tx_no_gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 12);
				burst_left = $urandom_range(1, 24);
				@(negedge clk) in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_tick();
		send_item(KIND_TICK, '0, '0);
	endtask

	// wait for every pending result, then let a level write settle
	task automatic drain();
		@(negedge clk) in_valid = 1'b0;
		while (shadow.due_readings.size() != 0) @(posedge clk);
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	task automatic apb_write(input vum_pkg::reg_idx_t r, input logic [31:0] v);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {r, 2'b00};
		pwdata  = v;
		@(negedge clk) penable = 1'b1;
		do @(posedge clk); while (!pready);
		shadow.write_reg(r, v);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// read back every register and compare with the shadow settings
	task automatic check_regs();
		vum_pkg::reg_idx_t r;
		for (int i = 0; i < 4; i++) begin
			r = vum_pkg::reg_idx_t'(i);
			@(negedge clk);
			psel    = 1'b1;
			penable = 1'b0;
			pwrite  = 1'b0;
			paddr   = {r, 2'b00};
			@(negedge clk) penable = 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== shadow.reg_value(r)) begin
				$display("%0t: register %s expected %0d actual %0d",
					$time, r.name(), shadow.reg_value(r), prdata);
				shadow.faults++;
			end
			@(negedge clk);
			psel    = 1'b0;
			penable = 1'b0;
		end
	endtask

	function automatic logic [31:0] pick_level_setting();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'd4096;
			2:       return 32'd8191;
			default: return $urandom_range(0, 700);
		endcase
	endfunction

	function automatic logic [31:0] pick_age_setting();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'd65535;
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	initial begin : stimulus
		logic        k;
		logic [2:0]  ch;
		logic [12:0] nl;

		// reset
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		check_regs();

		// reset settings: empty tick, extreme levels, saturation above full scale
		send_tick();
		send_item(KIND_LEVEL, 3'd0, 13'd4096);
		send_item(KIND_LEVEL, 3'd1, 13'd8191);
		send_item(KIND_LEVEL, 3'd2, 13'd1);
		send_item(KIND_LEVEL, 3'd3, 13'd4095);
		send_item(KIND_LEVEL, 3'd4, 13'd4097);
		send_tick();
		send_tick();

		// decay every tick, step under level and step over level, short hold
		drain();
		apb_write(vum_pkg::REG_DECAY_STEP, 32'd1000);
		apb_write(vum_pkg::REG_ZERO_FLOOR, 32'd500);
		apb_write(vum_pkg::REG_DECAY_INTERVAL, 32'd0);
		apb_write(vum_pkg::REG_HOLD_TIME, 32'd1);
		check_regs();
		send_item(KIND_LEVEL, 3'd0, 13'd4096);
		send_item(KIND_LEVEL, 3'd5, 13'd600);
		send_item(KIND_LEVEL, 3'd6, 13'd1400);
		repeat (4) send_tick();

		// zero step still counts as a change
		drain();
		apb_write(vum_pkg::REG_DECAY_STEP, 32'd0);
		apb_write(vum_pkg::REG_ZERO_FLOOR, 32'd0);
		apb_write(vum_pkg::REG_HOLD_TIME, 32'd0);
		check_regs();
		send_item(KIND_LEVEL, 3'd2, 13'd100);
		send_tick();
		send_tick();

		// full-scale step and floor
		drain();
		apb_write(vum_pkg::REG_DECAY_STEP, 32'd4096);
		apb_write(vum_pkg::REG_ZERO_FLOOR, 32'd4096);
		check_regs();
		send_item(KIND_LEVEL, 3'd3, 13'd4096);
		send_item(KIND_LEVEL, 3'd4, 13'd4095);
		send_tick();
		send_tick();

		// maximum interval and hold: nothing decays or drops, back to back
		drain();
		full_speed = 1'b1;
		tx_no_gaps = 1'b1;
		apb_write(vum_pkg::REG_DECAY_STEP, 32'd341);
		apb_write(vum_pkg::REG_ZERO_FLOOR, 32'd41);
		apb_write(vum_pkg::REG_DECAY_INTERVAL, 32'd65535);
		apb_write(vum_pkg::REG_HOLD_TIME, 32'd65535);
		check_regs();
		send_item(KIND_LEVEL, 3'd0, 13'd2000);
		send_item(KIND_LEVEL, 3'd1, 13'd3000);
		send_item(KIND_LEVEL, 3'd2, 13'd3000);
		send_tick();
		send_item(KIND_LEVEL, 3'd2, 13'd1000);
		repeat (4) send_tick();
		drain();
		full_speed = 1'b0;
		tx_no_gaps = 1'b0;

		// random phases, each under fresh settings
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			apb_write(vum_pkg::REG_DECAY_STEP, pick_level_setting());
			apb_write(vum_pkg::REG_ZERO_FLOOR, pick_level_setting());
			apb_write(vum_pkg::REG_DECAY_INTERVAL, pick_age_setting());
			apb_write(vum_pkg::REG_HOLD_TIME, pick_age_setting());
			check_regs();
			// first phase: receiver holds off while the sender keeps pushing
			if (phase == 0) begin
				squeeze = 1'b1;
				tx_no_gaps = 1'b1;
			end
			repeat (ITEMS_PER_PHASE) begin
				k  = 1'($urandom_range(0, 1));
				ch = 3'($urandom_range(0, 7));
				nl = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
					: 13'($urandom_range(0, 4096));
				send_item(k, ch, nl);
			end
			tx_no_gaps = 1'b0;
		end

		drain();
		if (shadow.faults == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
